// ----- sv/arctan_soft_clip_distortion_top_assert.svh -----
`ifndef ARCTAN_SOFT_CLIP_DISTORTION_TOP_ASSERT_SVH
`define ARCTAN_SOFT_CLIP_DISTORTION_TOP_ASSERT_SVH

// Same-cycle implication on clk_i, quiet while rst_ni is low.
`define ACSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, quiet while rst_ni is low.
`define ACSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/acsd_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register indexes and sideband type for the soft-clip distortion block.
package acsd_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned BLEND_W   = 17;
  localparam int unsigned MAG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd3;

  // Per-beat sideband that rides along the reciprocal divider
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;     // clean input sample
    logic                       big;   // argument above one, use reciprocal path
    logic                       zero;  // argument is zero
  } ctl_t;

endpackage

// ----- sv/arctan_soft_clip_distortion_top.sv -----
`timescale 1ns / 1ps
// Arctangent soft-clip distortion: Q1.15 sample in, shaped and saturated sample out.
// Pipeline: front stages, the reciprocal divider, then back stages; the
// reciprocal divider, one quotient bit per stage, sets most of that depth.
// Throughput: one beat per cycle unless stalled; empty stages close up under back-pressure.
// Reset: gains to 1.0, blend fully distorted, pipeline empty; no clearing pass.
`include "arctan_soft_clip_distortion_top_assert.svh"

module arctan_soft_clip_distortion_top #(
  parameter int unsigned ATAN_TABLE_DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic signed [acsd_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // [15:0] sample_in
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic signed [acsd_pkg::SAMPLE_W-1:0]  m_axis_tdata,  // [15:0] sample_out
  output logic                                  m_axis_tuser,  // [0] clipped
  input  logic                                  cfg_we_i,
  input  logic [acsd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [acsd_pkg::BLEND_W-1:0]          cfg_data_i
);

  localparam int unsigned AW      = $clog2(ATAN_TABLE_DEPTH);
  localparam int unsigned QW      = AW + 16;
  localparam int unsigned PW      = AW + 17;
  localparam int unsigned IW      = AW + 1;
  localparam int unsigned DW      = $clog2(ATAN_TABLE_DEPTH + 1);
  localparam int unsigned ARG_W   = 36;
  localparam int unsigned POSM_W  = ARG_W + DW;
  localparam int unsigned ROM_W   = 33;
  localparam int unsigned MIX_W   = 36;
  localparam int unsigned TOT_W   = 53;
  localparam int unsigned MAGN_W  = TOT_W - 1;
  localparam int unsigned RND_W   = MAGN_W - 28;

  localparam logic [acsd_pkg::GAIN_W-1:0]  DRIVE_RST  = 16'd4096;
  localparam logic [acsd_pkg::GAIN_W-1:0]  RANGE_RST  = 16'd256;
  localparam logic [acsd_pkg::GAIN_W-1:0]  VOLUME_RST = 16'd4096;
  localparam logic [acsd_pkg::BLEND_W-1:0] BLEND_ONE  = 17'h10000;
  localparam logic [16:0]                  SHAPE_ONE  = 17'h10000;
  localparam logic [16:0]                  TAB_END    = 17'd32768;
  localparam logic [acsd_pkg::MAG_W-1:0]   ARG_ONE    = 48'h8_0000_0000;
  localparam logic [MAGN_W:0]              ROUND_HALF = 53'h1000_0000;
  localparam logic [RND_W-1:0]             POS_LIM    = 24'd32767;
  localparam logic [RND_W-1:0]             NEG_LIM    = 24'd32768;
  localparam longint unsigned TWO_OVER_PI_Q30 = 64'd683565276;
  localparam longint unsigned SERIES_TERMS    = 64'd48;

  // ---------------------------------------------------------------------------
  // Arctangent table, built at elaboration
  // ---------------------------------------------------------------------------

  // Shift-subtract division for table generation only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(2/pi * atan(i/D) * 65536) via the Euler series, Q30 working format
  function automatic logic [15:0] atan_entry(longint unsigned i);
    longint unsigned one;
    longint unsigned u;
    longint unsigned sq;
    longint unsigned den;
    longint unsigned term;
    longint unsigned w;
    longint unsigned sum;
    longint unsigned rnd;
    one  = 64'd1 << 30;
    u    = udiv(i * one, 64'(ATAN_TABLE_DEPTH));
    sq   = (u * u) >> 30;
    den  = one + sq;
    term = udiv(u << 30, den);
    w    = udiv(sq << 30, den);
    sum  = term;
    for (longint unsigned k = 1; k <= SERIES_TERMS; k++) begin
      term = (term * w) >> 30;
      term = udiv(term * (2 * k), 2 * k + 1);
      sum  = sum + term;
    end
    rnd = (sum * TWO_OVER_PI_Q30 + (64'd1 << 43)) >> 44;
    if (i == 64'd0) begin
      rnd = 64'd0;
    end else if (i == 64'(ATAN_TABLE_DEPTH)) begin
      rnd = 64'd32768;
    end
    return rnd[15:0];
  endfunction

  // Entry a holds {rising, |T[a+1]-T[a]|, T[a]}
  logic [ROM_W-1:0] rom_w [ATAN_TABLE_DEPTH];

  for (genvar g = 0; g < ATAN_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [15:0] T_LO = atan_entry(64'(g));
    localparam logic [15:0] T_HI = atan_entry(64'(g + 1));
    localparam logic        UP   = T_HI >= T_LO;
    localparam logic [15:0] DIFF = UP ? 16'(T_HI - T_LO) : 16'(T_LO - T_HI);
    assign rom_w[g] = {UP, DIFF, T_LO};
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [acsd_pkg::GAIN_W-1:0]  drive_q;
  logic [acsd_pkg::GAIN_W-1:0]  range_q;
  logic [acsd_pkg::GAIN_W-1:0]  volume_q;
  logic [acsd_pkg::BLEND_W-1:0] blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q  <= DRIVE_RST;
      range_q  <= RANGE_RST;
      blend_q  <= BLEND_ONE;
      volume_q <= VOLUME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acsd_pkg::CFG_DRIVE:  drive_q  <= cfg_data_i[acsd_pkg::GAIN_W-1:0];
        acsd_pkg::CFG_RANGE:  range_q  <= cfg_data_i[acsd_pkg::GAIN_W-1:0];
        // Blend above one saturates to one
        acsd_pkg::CFG_BLEND:  blend_q  <= (cfg_data_i[16] && |cfg_data_i[15:0]) ?
                                          BLEND_ONE : cfg_data_i;
        acsd_pkg::CFG_VOLUME: volume_q <= cfg_data_i[acsd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stall chains, front (before divider) and back (after divider)
  // ---------------------------------------------------------------------------
  logic [2:0] va_q;
  logic [3:0] rdy_a;
  logic [7:0] vb_q;
  logic [8:0] rdy_b;
  logic       div_in_ready;
  logic       div_out_valid;

  assign rdy_a[3] = div_in_ready;
  assign rdy_b[8] = m_axis_tready;

  for (genvar k = 0; k < 3; k++) begin : g_rdy_a
    assign rdy_a[k] = !va_q[k] || rdy_a[k+1];
  end

  for (genvar k = 0; k < 8; k++) begin : g_rdy_b
    assign rdy_b[k] = !vb_q[k] || rdy_b[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
    end else begin
      if (rdy_a[0]) va_q[0] <= s_axis_tvalid;
      if (rdy_a[1]) va_q[1] <= va_q[0];
      if (rdy_a[2]) va_q[2] <= va_q[1];
      if (rdy_b[0]) vb_q[0] <= div_out_valid;
      if (rdy_b[1]) vb_q[1] <= vb_q[0];
      if (rdy_b[2]) vb_q[2] <= vb_q[1];
      if (rdy_b[3]) vb_q[3] <= vb_q[2];
      if (rdy_b[4]) vb_q[4] <= vb_q[3];
      if (rdy_b[5]) vb_q[5] <= vb_q[4];
      if (rdy_b[6]) vb_q[6] <= vb_q[5];
      if (rdy_b[7]) vb_q[7] <= vb_q[6];
    end
  end

  assign s_axis_tready = rdy_a[0];

  // ---------------------------------------------------------------------------
  // Front: |x| * drive, then * range, then argument classification
  // ---------------------------------------------------------------------------
  logic signed [acsd_pkg::SAMPLE_W-1:0] x0_q, x1_q;
  logic [acsd_pkg::SAMPLE_W-1:0]        ax_d;
  logic [31:0]                          p1_q;
  logic [acsd_pkg::MAG_W-1:0]           mag1_q, mag2_q;
  logic [POSM_W-1:0]                    pos_mul_d;
  logic [PW-1:0]                        pos_s_q;
  acsd_pkg::ctl_t                       ctl2_q;

  assign ax_d = s_axis_tdata[acsd_pkg::SAMPLE_W-1] ?
                acsd_pkg::SAMPLE_W'(-s_axis_tdata) : s_axis_tdata;

  // Stage A0: drive product
  always_ff @(posedge clk_i) begin
    if (rdy_a[0]) begin
      x0_q <= s_axis_tdata;
      p1_q <= 32'(ax_d) * 32'(drive_q);
    end
  end

  // Stage A1: range product, argument in Q13.35
  always_ff @(posedge clk_i) begin
    if (rdy_a[1]) begin
      x1_q   <= x0_q;
      mag1_q <= acsd_pkg::MAG_W'(p1_q) * acsd_pkg::MAG_W'(range_q);
    end
  end

  // Stage A2: direct table position for arguments up to one
  assign pos_mul_d = POSM_W'(mag1_q[ARG_W-1:0]) * POSM_W'(ATAN_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (rdy_a[2]) begin
      mag2_q      <= mag1_q;
      pos_s_q     <= pos_mul_d[19 +: PW];
      ctl2_q.x    <= x1_q;
      ctl2_q.big  <= mag1_q > ARG_ONE;
      ctl2_q.zero <= mag1_q == '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Reciprocal position D * 2^51 / arg for arguments above one
  // ---------------------------------------------------------------------------
  logic [QW-1:0]  div_quo;
  logic [PW-1:0]  div_pos;
  acsd_pkg::ctl_t div_ctl;

  acsd_recip_div #(
    .DEPTH (ATAN_TABLE_DEPTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (va_q[2]),
    .in_ready_o  (div_in_ready),
    .mag_i       (mag2_q),
    .pos_i       (pos_s_q),
    .ctl_i       (ctl2_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy_b[0]),
    .quo_o       (div_quo),
    .pos_o       (div_pos),
    .ctl_o       (div_ctl)
  );

  // ---------------------------------------------------------------------------
  // Back: table read, interpolation, blend, volume, rounding
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    pos_d;
  logic [IW-1:0]    idx_d;
  logic             sat_d;
  logic [AW-1:0]    rom_addr;
  logic [ROM_W-1:0] rom_q;
  logic [15:0]      f_q;
  logic             sat0_q, sat1_q;
  acsd_pkg::ctl_t   ctl_b0_q, ctl_b1_q;

  assign pos_d    = div_ctl.big ? PW'(div_quo) : div_pos;
  assign idx_d    = pos_d[PW-1:16];
  assign sat_d    = idx_d >= IW'(ATAN_TABLE_DEPTH);
  assign rom_addr = sat_d ? '0 : idx_d[AW-1:0];

  // Stage B0: registered table read
  always_ff @(posedge clk_i) begin
    if (rdy_b[0]) begin
      rom_q    <= rom_w[rom_addr];
      f_q      <= pos_d[15:0];
      sat0_q   <= sat_d;
      ctl_b0_q <= div_ctl;
    end
  end

  // Stage B1: slope times fraction
  logic [31:0] slope_d;
  logic [15:0] prod_q;
  logic [15:0] lo_q;
  logic        up_q;

  assign slope_d = 32'(rom_q[31:16]) * 32'(f_q);

  always_ff @(posedge clk_i) begin
    if (rdy_b[1]) begin
      prod_q   <= slope_d[31:16];
      lo_q     <= rom_q[15:0];
      up_q     <= rom_q[32];
      sat1_q   <= sat0_q;
      ctl_b1_q <= ctl_b0_q;
    end
  end

  // Stage B2: interpolated value, mirrored for reciprocal arguments
  logic [16:0]                          interp_d;
  logic [16:0]                          shape_d;
  logic [16:0]                          s_q;
  logic signed [acsd_pkg::SAMPLE_W-1:0] x_b2_q;

  always_comb begin
    if (sat1_q) begin
      interp_d = TAB_END;
    end else if (up_q) begin
      interp_d = {1'b0, lo_q} + {1'b0, prod_q};
    end else begin
      interp_d = {1'b0, lo_q} - {1'b0, prod_q};
    end
    if (ctl_b1_q.zero) begin
      shape_d = '0;
    end else if (ctl_b1_q.big) begin
      shape_d = SHAPE_ONE - interp_d;
    end else begin
      shape_d = interp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b[2]) begin
      s_q    <= shape_d;
      x_b2_q <= ctl_b1_q.x;
    end
  end

  // Stage B3: wet and dry products
  logic signed [17:0]                   y_d;
  logic [acsd_pkg::BLEND_W-1:0]         nb_d;
  logic signed [35:0]                   pa_d, pa_q;
  logic signed [33:0]                   pb_d, pb_q;

  assign y_d  = x_b2_q[acsd_pkg::SAMPLE_W-1] ? -$signed({1'b0, s_q}) : $signed({1'b0, s_q});
  assign nb_d = BLEND_ONE - blend_q;
  assign pa_d = 36'(y_d) * 36'($signed({1'b0, blend_q}));
  assign pb_d = 34'(x_b2_q) * 34'($signed({1'b0, nb_d}));

  always_ff @(posedge clk_i) begin
    if (rdy_b[3]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  // Stage B4: mix sum in Q.32
  logic signed [MIX_W-1:0] mix_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b[4]) begin
      mix_q <= MIX_W'(pa_q) + MIX_W'(pb_q);
    end
  end

  // Stage B5: volume, Q.44
  logic signed [TOT_W-1:0] total_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b[5]) begin
      total_q <= TOT_W'(mix_q) * TOT_W'($signed({1'b0, volume_q}));
    end
  end

  // Stage B6: sign and magnitude
  logic [MAGN_W-1:0] magn_q;
  logic              neg_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b[6]) begin
      neg_q  <= total_q[TOT_W-1];
      magn_q <= total_q[TOT_W-1] ? MAGN_W'(-total_q) : MAGN_W'(total_q);
    end
  end

  // Stage B7: round half away from zero, saturate to Q1.15
  logic [MAGN_W:0]                      rsum_d;
  logic [RND_W-1:0]                     r_d;
  logic signed [acsd_pkg::SAMPLE_W-1:0] res_d, out_q;
  logic                                 clip_d, clip_q;

  assign rsum_d = {1'b0, magn_q} + ROUND_HALF;
  assign r_d    = rsum_d[MAGN_W:29];

  always_comb begin
    clip_d = 1'b0;
    if (!neg_q) begin
      if (r_d > POS_LIM) begin
        clip_d = 1'b1;
        res_d  = POS_LIM[acsd_pkg::SAMPLE_W-1:0];
      end else begin
        res_d  = r_d[acsd_pkg::SAMPLE_W-1:0];
      end
    end else begin
      if (r_d > NEG_LIM) begin
        clip_d = 1'b1;
        res_d  = NEG_LIM[acsd_pkg::SAMPLE_W-1:0];
      end else begin
        res_d  = -r_d[acsd_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b[7]) begin
      out_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign m_axis_tvalid = vb_q[7];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = clip_q;

  // Checks
  `ACSD_ASSERT_IMP(a_clip_is_rail, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'sh7fff || m_axis_tdata == -16'sh8000, "clip flag on a sample off the rails")
  `ACSD_ASSERT_IMP(a_shape_bound, vb_q[2], s_q <= SHAPE_ONE, "shaped value above one")
  `ACSD_ASSERT_IMP(a_blocked_full, !s_axis_tready, (&va_q) && (&vb_q) && !m_axis_tready, "input refused while a stage is empty")

endmodule

// ----- sv/acsd_recip_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: DEPTH * 2^51 / mag, one quotient bit per stage.
`include "arctan_soft_clip_distortion_top_assert.svh"

module acsd_recip_div #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned QW = AW + 16,
  localparam int unsigned PW = AW + 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [acsd_pkg::MAG_W-1:0] mag_i,
  input  logic [PW-1:0]              pos_i,
  input  acsd_pkg::ctl_t             ctl_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [QW-1:0]              quo_o,
  output logic [PW-1:0]              pos_o,
  output acsd_pkg::ctl_t             ctl_o
);

  // Top part of the constant dividend; always below a divisor above 2^35
  localparam logic [acsd_pkg::MAG_W-1:0] REM_INIT =
    acsd_pkg::MAG_W'(DEPTH) << (35 - AW);
  localparam logic [PW-1:0] POS_MAX = PW'(DEPTH) << 16;

  logic                       v_q   [QW];
  logic [QW-1:0]              v_vec;
  logic [QW:0]                rdy;
  logic [acsd_pkg::MAG_W-1:0] rem_q [QW];
  logic [acsd_pkg::MAG_W-1:0] div_q [QW];
  logic [QW-1:0]              quo_q [QW];
  logic [PW-1:0]              pos_q [QW];
  acsd_pkg::ctl_t             ctl_q [QW];

  assign rdy[QW] = out_ready_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                       v_in;
    logic [acsd_pkg::MAG_W-1:0] rem_in;
    logic [acsd_pkg::MAG_W-1:0] div_in;
    logic [QW-1:0]              quo_in;
    logic [PW-1:0]              pos_in;
    acsd_pkg::ctl_t             ctl_in;
    logic [acsd_pkg::MAG_W:0]   trial;
    logic                       ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = REM_INIT;
      assign div_in = mag_i;
      assign quo_in = '0;
      assign pos_in = pos_i;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
      assign pos_in = pos_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    // Stall chain: a stage moves when empty or when the next one moves
    assign rdy[k]   = !v_q[k] || rdy[k+1];
    assign v_vec[k] = v_q[k];

    // One compare-subtract step
    assign trial = {rem_in, 1'b0};
    assign ge    = trial >= {1'b0, div_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k] <= ge ? acsd_pkg::MAG_W'(trial - {1'b0, div_in})
                       : trial[acsd_pkg::MAG_W-1:0];
        div_q[k] <= div_in;
        quo_q[k] <= {quo_in[QW-2:0], ge};
        pos_q[k] <= pos_in;
        ctl_q[k] <= ctl_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QW-1];
  assign quo_o       = quo_q[QW-1];
  assign pos_o       = pos_q[QW-1];
  assign ctl_o       = ctl_q[QW-1];

  // Checks
  `ACSD_ASSERT_NXT(a_accept_lands, in_valid_i && in_ready_o, v_q[0], "accepted beat missing from first divider stage")
  `ACSD_ASSERT_IMP(a_rem_below_div, v_q[QW-1] && ctl_q[QW-1].big, rem_q[QW-1] < div_q[QW-1], "divider remainder not below divisor")
  `ACSD_ASSERT_IMP(a_quo_range, v_q[QW-1] && ctl_q[QW-1].big, PW'(quo_q[QW-1]) < POS_MAX, "reciprocal position beyond table end")
  `ACSD_ASSERT_IMP(a_full_when_blocked, !in_ready_o, $countones(v_vec) == QW, "divider refuses a beat while a stage is empty")

endmodule

// ----- tb/sv/soft_clip_checker.sv -----
`timescale 1ns / 1ps
// Watches the sample streams and gain writes, predicts each shaped sample and compares.
module soft_clip_checker #(
  parameter int unsigned ATAN_TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [acsd_pkg::SAMPLE_W-1:0] in_data_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [acsd_pkg::SAMPLE_W-1:0] out_data_i,
  input  logic                                 out_clip_i,
  input  logic                                 cfg_we_i,
  input  logic [acsd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [acsd_pkg::BLEND_W-1:0]         cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import acsd_pkg::*;

  localparam longint unsigned DEPTH_L     = ATAN_TABLE_DEPTH;
  localparam longint unsigned ARG_UNITY   = 64'd1 << 35;
  localparam longint unsigned TWO_OVER_PI = 64'd683565276; // 2/pi in Q30

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;      // input that caused it, for reports
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } shaped_t;

  longint unsigned atan_tab [0:ATAN_TABLE_DEPTH];

  // Local copy of the gain registers
  logic [GAIN_W-1:0]  drive_q;
  logic [GAIN_W-1:0]  range_q;
  logic [BLEND_W-1:0] blend_q;
  logic [GAIN_W-1:0]  volume_q;

  shaped_t shaped_q [$];

  // Arctangent table, 2/pi * atan(i/D) in Q.16, via the Euler series in Q30
  initial begin : build_atan
    longint unsigned one, u, sq, den, term, w, sum;
    one = 64'd1 << 30;
    for (int i = 0; i <= ATAN_TABLE_DEPTH; i++) begin
      u    = longint'(i) * one / DEPTH_L;
      sq   = (u * u) >> 30;
      den  = one + sq;
      term = (u << 30) / den;
      w    = (sq << 30) / den;
      sum  = term;
      for (longint unsigned k = 1; k <= 48; k++) begin
        term = (term * w) >> 30;
        term = term * (2 * k) / (2 * k + 1);
        sum  = sum + term;
      end
      atan_tab[i] = (sum * TWO_OVER_PI + (64'd1 << 43)) >> 44;
    end
    atan_tab[0]                = 0;
    atan_tab[ATAN_TABLE_DEPTH] = 32768;
  end

  // Linear interpolation between table points, pos in Q.16 index units
  function automatic longint unsigned atan_lookup(longint unsigned pos);
    longint unsigned idx, frac, lo, hi;
    idx  = pos >> 16;
    frac = pos & 64'hFFFF;
    if (idx >= DEPTH_L) return atan_tab[ATAN_TABLE_DEPTH];
    lo = atan_tab[idx];
    hi = atan_tab[idx + 1];
    if (hi >= lo) return lo + (((hi - lo) * frac) >> 16);
    return lo - (((lo - hi) * frac) >> 16);
  endfunction

  // Full sample path: drive, arctangent shaping, blend with clean, volume, saturate
  function automatic shaped_t shape_sample(logic signed [SAMPLE_W-1:0] x);
    longint          xs, y, b, mix, total;
    longint unsigned ax, mag, s, m, r;
    logic            neg;
    shaped_t         res;
    xs  = x;
    ax  = (xs < 0) ? -xs : xs;
    mag = ax * drive_q * range_q;
    if (mag == 0) s = 0;
    else if (mag <= ARG_UNITY) s = atan_lookup((mag * DEPTH_L) >> 19);
    else s = 65536 - atan_lookup((DEPTH_L << 51) / mag);
    y     = (xs < 0) ? -$signed(s) : $signed(s);
    // blend above one counts as fully shaped
    b     = (blend_q > 17'd65536) ? 65536 : longint'(blend_q);
    mix   = y * b + xs * (65536 - b);
    total = mix * longint'(volume_q);
    neg   = total < 0;
    m     = neg ? -total : total;
    r     = (m + (64'd1 << 28)) >> 29;
    res.x    = x;
    res.clip = 1'b0;
    if (!neg) begin
      if (r > 32767) begin
        r        = 32767;
        res.clip = 1'b1;
      end
      res.sample = 16'(r);
    end else begin
      if (r > 32768) begin
        r        = 32768;
        res.clip = 1'b1;
      end
      res.sample = 16'(64'd0 - r);
    end
    return res;
  endfunction

  // Compare first, then queue the new prediction, then take gain writes
  always @(posedge clk_i or negedge rst_ni) begin
    shaped_t want;
    if (!rst_ni) begin
      drive_q      <= 16'd4096;
      range_q      <= 16'd256;
      blend_q      <= 17'd65536;
      volume_q     <= 16'd4096;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: output beat %0d/%0b with nothing outstanding",
                     $realtime, out_data_i, out_clip_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = shaped_q.pop_front();
          if (out_data_i !== want.sample || out_clip_i !== want.clip) begin
            if (fail_count_o < 10)
              $display("%0t: in %0d: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                       $realtime, want.x, want.sample, out_data_i, want.clip, out_clip_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) shaped_q.push_back(shape_sample(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DRIVE:  drive_q  <= cfg_data_i[GAIN_W-1:0];
          CFG_RANGE:  range_q  <= cfg_data_i[GAIN_W-1:0];
          CFG_BLEND:  blend_q  <= cfg_data_i;
          CFG_VOLUME: volume_q <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      pending_o <= shaped_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_arctan_soft_clip_distortion_top.sv -----
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the arctangent soft-clip distortion block.
module tb_arctan_soft_clip_distortion_top;
  import acsd_pkg::*;

  localparam int unsigned ATAN_DEPTH = 256;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic signed [SAMPLE_W-1:0] s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic signed [SAMPLE_W-1:0] m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i     = CFG_DRIVE;
  logic [BLEND_W-1:0]         cfg_data_i    = '0;

  int   fails;
  int   pending;
  logic send_free  = 1'b0; // sender never idles
  logic ready_free = 1'b0; // receiver never stalls
  int   ready_run  = 0;

  arctan_soft_clip_distortion_top #(
    .ATAN_TABLE_DEPTH(ATAN_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  soft_clip_checker #(
    .ATAN_TABLE_DEPTH(ATAN_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_clip_i  (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] raw;
    case ($urandom_range(0, 9))
      0: raw = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2: begin
        raw = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) raw = -raw;
      end
      default: raw = 16'($urandom);
    endcase
    return raw;
  endfunction

  // Receiver: alternating ready and stall stretches, or ready throughout
  always @(posedge clk_i) begin
    if (ready_free) begin
      m_axis_tready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      ready_run     <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
      ready_run     <= $urandom_range(0, 12);
    end
  end

  // One input beat, with an optional idle gap in front
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = send_free ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off the sender until every outstanding sample has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_gains(input logic [BLEND_W-1:0] drive, input logic [BLEND_W-1:0] rng,
                            input logic [BLEND_W-1:0] blend, input logic [BLEND_W-1:0] vol);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DRIVE;
    cfg_data_i <= drive;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RANGE;
    cfg_data_i <= rng;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLEND;
    cfg_data_i <= blend;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VOLUME;
    cfg_data_i <= vol;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [BLEND_W-1:0] drive, rng, blend, vol;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: full scale negative lands exactly on an argument of one
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd16384);

    // Maximum gains, spare drive bit set, blend above one: heavy saturation
    drain_results();
    load_gains(17'h1FFFF, 17'h0FFFF, 17'h1FFFF, 17'h1FFFF);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);

    // All gains zero: zero argument, silent output
    drain_results();
    load_gains(17'd0, 17'd0, 17'd0, 17'd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);

    // Half blend with full volume: clean share saturates too
    drain_results();
    load_gains(17'd4096, 17'd256, 17'd32768, 17'd65535);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd12345);
    send_sample(-16'sd12345);

    // Tiny drive: deep in the small-argument part of the table
    drain_results();
    load_gains(17'd1, 17'd1, 17'd65536, 17'd4096);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd100);

    // Random phases, each with fresh gains and its own idling pattern
    for (int ph = 0; ph < 12; ph++) begin
      drain_results();
      case ($urandom_range(0, 3))
        0: drive = 17'd0;
        1: drive = 17'hFFFF;
        default: drive = 17'($urandom_range(1, 16384));
      endcase
      case ($urandom_range(0, 3))
        0: rng = 17'hFFFF;
        1: rng = 17'd0;
        default: rng = 17'($urandom_range(1, 1024));
      endcase
      case ($urandom_range(0, 4))
        0: blend = 17'd0;
        1: blend = 17'd65536;
        2: blend = 17'($urandom_range(65537, 131071));
        default: blend = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 4))
        0: vol = 17'd0;
        1: vol = 17'hFFFF;
        default: vol = 17'($urandom_range(0, 12288));
      endcase
      // spare top bit on the 16-bit registers must be dropped
      drive[GAIN_W] = 1'($urandom_range(0, 1));
      rng[GAIN_W]   = 1'($urandom_range(0, 1));
      vol[GAIN_W]   = 1'($urandom_range(0, 1));
      load_gains(drive, rng, blend, vol);
      send_free  <= ($urandom_range(0, 3) == 0);
      ready_free <= ($urandom_range(0, 3) == 0);
      repeat (50) send_sample(rand_sample());
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("arctan_soft_clip_distortion_top test passed");
    end else begin
      $display("arctan_soft_clip_distortion_top test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("arctan_soft_clip_distortion_top test failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/acsd_pkg.sv
sv/acsd_recip_div.sv
sv/arctan_soft_clip_distortion_top.sv
tb/sv/soft_clip_checker.sv
tb/sv/tb_arctan_soft_clip_distortion_top.sv
